@@ src/pcg_pkg.sv @@
// Shared types, codes and the brute-force character table for the
// password candidate generator. No dependencies.
`default_nettype none
package pcg_pkg;

    localparam int ADDR_W = 17;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_NEXT    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_CAPS    = 3'd1;
    localparam logic [2:0] MODE_LEET    = 3'd2;
    localparam logic [2:0] MODE_LCAPS   = 3'd3;
    localparam logic [2:0] MODE_SCAPS   = 3'd4;
    localparam logic [2:0] MODE_SLEET   = 3'd5;
    localparam logic [2:0] MODE_BRUTE   = 3'd6;
    localparam logic [2:0] MODE_DONE    = 3'd7;

    localparam logic [6:0] CHARSET_SIZE = 7'd90;
    localparam logic [6:0] CHARSET_LAST = 7'd89;

    localparam logic [0:89][7:0] CHARSET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789!@#$%^&*()[{]}/?=+-_'\\\";<>,.";

    localparam logic [0:0] REG_MAX_LENGTH = 1'd0;
    localparam logic [0:0] REG_WL_BYTES   = 1'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] candidate_char;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_GEN,
        S_FIN,
        S_ERD,
        S_EWR
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic gen_char;
        logic gen_end;
        logic fin;
        logic emit_char;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic dup;
        logic at_end;
        logic slot_free;
    } t_sts;

    function automatic logic [7:0] charset_at(input logic [6:0] idx);
        logic [7:0] c;
        c = 8'd0;
        if (idx < CHARSET_SIZE) begin
            c = CHARSET[idx];
        end
        return c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "a" && c <= "z") begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_leet(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == "o") begin
            r = "0";
        end else if (c == "e") begin
            r = "3";
        end else if (c == "i") begin
            r = "1";
        end
        return r;
    endfunction

    function automatic logic [7:0] shift_one(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "a" && c <= "z") begin
            r = c - 8'd32;
        end else if (c >= "2" && c <= "9") begin
            r = c - 8'd1;
        end else if (c == "0") begin
            r = "O";
        end else if (c == "1") begin
            r = "!";
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/pcg_ctrl.sv @@
// Controller state machine of the candidate generator.
// Depends on pcg_pkg; drives commands to pcg_dp from its status.
`default_nettype none
module pcg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_kind,
    input  wire pcg_pkg::t_sts i_sts,
    output pcg_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);
    import pcg_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_kind == KIND_NEXT) begin
                    n_state = S_START;
                end
            end
            S_START: n_state = S_GEN;
            S_GEN: begin
                if (!i_sts.more) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = i_sts.dup ? S_START : S_ERD;
            S_ERD: n_state = S_EWR;
            S_EWR: begin
                if (i_sts.slot_free) begin
                    n_state = i_sts.at_end ? S_IDLE : S_ERD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_START: o_cmd.start = 1'b1;
            S_GEN: begin
                o_cmd.gen_char = i_sts.more;
                o_cmd.gen_end  = !i_sts.more;
            end
            S_FIN: o_cmd.fin = !i_sts.dup;
            S_ERD: ;
            S_EWR: begin
                o_cmd.emit_char = i_sts.slot_free && !i_sts.at_end;
                o_cmd.emit_last = i_sts.slot_free && i_sts.at_end;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ src/pcg_dp.sv @@
// Datapath of the candidate generator: wordlist memory, candidate buffers,
// pass state, base-90 counter and output register. Depends on pcg_pkg.
`default_nettype none
module pcg_dp #(
    parameter int WORDLIST_DEPTH = 4096,
    parameter int MAX_CANDIDATE  = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [6:0]    i_max_length,
    input  wire logic [12:0]   i_wl_bytes,
    input  wire pcg_pkg::t_in  i_in,
    input  wire pcg_pkg::t_cmd i_cmd,
    output pcg_pkg::t_sts      o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output pcg_pkg::t_out      o_out
);
    import pcg_pkg::*;

    localparam int AW = $clog2(WORDLIST_DEPTH);
    localparam int BW = $clog2(MAX_CANDIDATE);
    localparam int IW = BW + 1;

    logic [7:0]        r_wmem [WORDLIST_DEPTH];
    logic [7:0]        r_rdata;
    logic [7:0]        r_b0 [MAX_CANDIDATE];
    logic [7:0]        r_b1 [MAX_CANDIDATE];
    logic [7:0]        r_d0, r_d1;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_len, r_plen;
    logic [2:0]        r_mode;
    logic [12:0]       r_wo;
    logic [5:0]        r_cp;
    logic [6:0]        r_dig [7];
    logic [6:0]        n_dig [7];
    logic              n_carry;
    logic [2:0]        r_blen;
    logic              r_sel, r_diff, r_exh;
    logic              r_oval;
    logic [7:0]        r_ochar;
    logic              r_olast;
    logic [6:0]        lim, ml;
    logic [7:0]        wchar, dcur, dprev;
    logic [ADDR_W-1:0] a1;
    logic [6:0]        cpn;
    logic              next_pass;
    logic [12:0]       wo_n;
    logic [5:0]        cp_n;
    logic              load_ok;

    assign load_ok = {{(ADDR_W-12){1'b0}}, i_in.load_address} < ADDR_W'(WORDLIST_DEPTH);
    assign dcur    = r_sel ? r_d1 : r_d0;
    assign dprev   = r_sel ? r_d0 : r_d1;
    assign a1      = r_addr + 1'b1;
    assign cpn     = 7'(r_cp) + 7'd1;

    always_comb begin
        ml = i_max_length;
        if (ml < 7'd2) begin
            ml = 7'd2;
        end else if (ml > 7'(MAX_CANDIDATE)) begin
            ml = 7'(MAX_CANDIDATE);
        end
        lim = ml - 7'd1;
    end

    always_comb begin
        wchar = r_rdata;
        case (r_mode)
            MODE_CAPS:  wchar = to_upper(r_rdata);
            MODE_LEET:  wchar = to_leet(r_rdata);
            MODE_LCAPS: wchar = to_upper(to_leet(r_rdata));
            MODE_SCAPS: wchar = (7'(r_i) == 7'(r_cp)) ? shift_one(r_rdata) : r_rdata;
            MODE_SLEET: wchar = (7'(r_i) == 7'(r_cp)) ? to_leet(r_rdata) : r_rdata;
            MODE_BRUTE: wchar = charset_at(r_dig[r_i[2:0]]);
            default:    wchar = r_rdata;
        endcase
    end

    always_comb begin
        o_sts.more = 1'b0;
        case (r_mode)
            MODE_BRUTE: o_sts.more = (7'(r_i) < lim) && (7'(r_i) < 7'(r_blen));
            MODE_DONE:  o_sts.more = 1'b0;
            default:    o_sts.more = (7'(r_i) < lim) && (r_rdata != 8'd0);
        endcase
        o_sts.dup       = !r_exh && (r_len == r_plen) && !r_diff;
        o_sts.at_end    = (r_i == r_len);
        o_sts.slot_free = !r_oval || i_out_ready;
    end

    always_comb begin
        n_carry = 1'b1;
        for (int k = 0; k < 7; k++) begin
            n_dig[k] = r_dig[k];
            if (3'(k) < r_blen && n_carry) begin
                if (r_dig[k] == CHARSET_LAST) begin
                    n_dig[k] = 7'd0;
                end else begin
                    n_dig[k] = r_dig[k] + 7'd1;
                    n_carry  = 1'b0;
                end
            end
        end
    end

    always_comb begin
        next_pass = 1'b0;
        wo_n      = r_wo;
        cp_n      = r_cp;
        if (r_mode == MODE_SCAPS || r_mode == MODE_SLEET) begin
            if (cpn >= 7'(r_i)) begin
                cp_n = 6'd0;
                wo_n = a1[12:0];
                next_pass = a1 >= ADDR_W'(i_wl_bytes);
            end else begin
                cp_n = cpn[5:0];
                next_pass = r_wo >= i_wl_bytes;
            end
        end else begin
            wo_n      = a1[12:0];
            next_pass = a1 >= ADDR_W'(i_wl_bytes);
        end
    end

    always_comb begin
        n_addr = r_addr;
        n_i    = r_i;
        if (i_cmd.start) begin
            n_addr = ADDR_W'(r_wo);
            n_i    = '0;
        end else if (i_cmd.gen_char) begin
            n_addr = a1;
            n_i    = r_i + 1'b1;
        end else if (i_cmd.fin) begin
            n_i = '0;
        end else if (i_cmd.emit_char) begin
            n_i = r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.kind == KIND_LOAD && load_ok) begin
            r_wmem[AW'(i_in.load_address)] <= i_in.load_byte;
        end
        r_rdata <= r_wmem[n_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_char && !r_sel) begin
            r_b0[r_i[BW-1:0]] <= wchar;
        end
        r_d0 <= r_b0[n_i[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_char && r_sel) begin
            r_b1[r_i[BW-1:0]] <= wchar;
        end
        r_d1 <= r_b1[n_i[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_cmd.start) begin
            r_diff <= 1'b0;
            r_exh  <= (r_mode == MODE_DONE);
        end
        if (i_cmd.gen_char && (r_i < r_plen) && (wchar != dprev)) begin
            r_diff <= 1'b1;
        end
        if (i_cmd.gen_end) begin
            r_len <= r_i;
        end
        if (i_cmd.emit_char || i_cmd.emit_last) begin
            r_ochar <= i_cmd.emit_last ? 8'd0 : dcur;
            r_olast <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_plen <= '0;
            r_sel  <= 1'b0;
            r_oval <= 1'b0;
            r_mode <= MODE_PLAIN;
            r_wo   <= '0;
            r_cp   <= '0;
            r_blen <= 3'd1;
            for (int k = 0; k < 7; k++) begin
                r_dig[k] <= 7'd0;
            end
        end else begin
            r_i <= n_i;
            if (i_cmd.emit_char || i_cmd.emit_last) begin
                r_oval <= 1'b1;
            end else if (i_out_ready) begin
                r_oval <= 1'b0;
            end
            if (i_cmd.emit_last) begin
                r_sel  <= !r_sel;
                r_plen <= r_len;
            end
            if (i_cmd.accept && i_in.kind == KIND_RESTART) begin
                r_mode <= MODE_PLAIN;
                r_wo   <= '0;
                r_cp   <= '0;
                r_blen <= 3'd1;
                for (int k = 0; k < 7; k++) begin
                    r_dig[k] <= 7'd0;
                end
            end else if (i_cmd.gen_end) begin
                if (r_mode == MODE_BRUTE) begin
                    r_dig <= n_dig;
                    if (n_carry) begin
                        if (r_blen == 3'd7) begin
                            r_mode <= MODE_DONE;
                        end else begin
                            r_blen <= r_blen + 3'd1;
                        end
                    end
                end else if (r_mode != MODE_DONE) begin
                    if (next_pass) begin
                        r_mode <= r_mode + 3'd1;
                        r_wo   <= '0;
                        r_cp   <= '0;
                    end else begin
                        r_wo <= wo_n;
                        r_cp <= cp_n;
                    end
                end
            end
        end
    end

    assign o_out_valid          = r_oval;
    assign o_out.candidate_char = r_ochar;
    assign o_out.last           = r_olast;

endmodule
`default_nettype wire

@@ src/password_candidate_generator_top.sv @@
// Top level of the password candidate generator: APB register file and the
// controller and datapath. Depends on pcg_pkg, pcg_ctrl and pcg_dp.
//
// Input channel (i_in_valid/o_in_ready) takes one word per item: a load
// writes one wordlist byte, a restart returns to the first pass, a next
// item produces one candidate. Load, restart and unknown kinds give no
// output. A next item yields the candidate characters on the output
// channel (o_out_valid/i_out_ready), one word each, closed by a zero word
// with last set. Generation reads the wordlist memory one byte a cycle;
// each skipped duplicate of the previous candidate adds its generation
// time again. Emission passes each character through the ERD and EWR
// states and a single output register.
// The block takes no new item until the terminator sits in the output
// register; a stalled receiver holds emission. Reset clears the pass state
// and the previous candidate; the wordlist memory is not cleared.
`default_nettype none
module password_candidate_generator_top #(
    parameter int WORDLIST_DEPTH = 4096,
    parameter int MAX_CANDIDATE  = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pcg_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pcg_pkg::t_out      o_out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pcg_pkg::*;

    logic [6:0]  r_max_length;
    logic [12:0] r_wl_bytes;
    t_cmd        cmd;
    t_sts        sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= 7'd16;
            r_wl_bytes   <= 13'd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MAX_LENGTH: r_max_length <= pwdata[6:0];
                REG_WL_BYTES:   r_wl_bytes   <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_LENGTH: prdata = {25'd0, r_max_length};
            REG_WL_BYTES:   prdata = {19'd0, r_wl_bytes};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    pcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    pcg_dp #(
        .WORDLIST_DEPTH (WORDLIST_DEPTH),
        .MAX_CANDIDATE  (MAX_CANDIDATE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_wl_bytes   (r_wl_bytes),
        .i_in         (i_in_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out_data)
    );

endmodule
`default_nettype wire
